@@ design/ttsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ttsm_pkg
// Shared types and constants of the table-driven trie string matcher.
// ----------------------------------------------------------------------------
package ttsm_pkg;

  localparam int NODE_W  = 8;
  localparam int SYM_W8  = 8;
  localparam int ENTRY_W = NODE_W + 1;

  localparam logic [NODE_W-1:0] ROOT_NODE = 8'd1;
  localparam logic [NODE_W-1:0] NO_LINK   = 8'd0;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CHAR  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] entry_node;
    logic [SYM_W8-1:0] symbol;
    logic [NODE_W-1:0] next_node;
    logic              accept;
    logic              last;
  } ttsm_in_t;

  typedef struct packed {
    logic accepted;
    logic stopped_early;
  } ttsm_out_t;

endpackage

@@ design/ttsm_ram.sv @@
// ----------------------------------------------------------------------------
// ttsm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ttsm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/trie_table_string_matcher.sv @@
// ----------------------------------------------------------------------------
// trie_table_string_matcher
// Walks a (node, byte) transition table held in one synchronous RAM.
// ----------------------------------------------------------------------------
// table writes and characters while skipping: one request per cycle
// character lookup: RAM read, then next-node update in ST_LOOKUP; the next character
// waits for the update, as the next table address depends on the node just read
// result is registered, set in ST_LOOKUP after the RAM read; a held output stalls ST_LOOKUP
// reset: clearing pass writes zero to every entry, 2^(row bits + symbol bits)
// entries (65536 by default), with in_ready low until it ends
module trie_table_string_matcher
  import ttsm_pkg::*;
#(
  parameter int NODE_COUNT   = 256,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ttsm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ttsm_out_t out_data
);

  localparam int ROW_COUNT = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int ROW_W     = $clog2(ROW_COUNT);
  localparam int SYM_W     = $clog2(SYMBOL_COUNT);
  localparam int ADDR_W    = ROW_W + SYM_W;
  localparam int DEPTH     = 1 << ADDR_W;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [NODE_W-1:0] cur_node_r, cur_node_nxt;
  logic              skipping_r, skipping_nxt;
  logic              last_r, last_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  ttsm_out_t         out_data_r, out_data_nxt;

  logic               in_fire;
  logic               wr_ok;
  logic               rd_ok;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [ENTRY_W-1:0] entry;
  logic [NODE_W-1:0]  link;
  logic               need_out;
  logic               can_emit;

  ttsm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;

  assign wr_ok = ({24'd0, in_data.entry_node} < 32'(NODE_COUNT)) &&
                 ({24'd0, in_data.symbol} < 32'(SYMBOL_COUNT));
  assign rd_ok = ({24'd0, cur_node_r} < 32'(NODE_COUNT)) &&
                 ({24'd0, in_data.symbol} < 32'(SYMBOL_COUNT));

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    mem_addr  = {cur_node_r[ROW_W-1:0], in_data.symbol[SYM_W-1:0]};
    if (state_r == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_r;
    end else if (in_data.kind == KIND_WRITE) begin
      mem_we    = in_fire & wr_ok;
      mem_addr  = {in_data.entry_node[ROW_W-1:0], in_data.symbol[SYM_W-1:0]};
      mem_wdata = {in_data.accept, in_data.next_node};
    end else begin
      mem_re = in_fire & ~skipping_r;
    end
  end

  // out-of-range entries read as zero
  assign entry    = hit_r ? mem_rdata : '0;
  assign link     = entry[NODE_W-1:0];
  assign need_out = last_r | (link == NO_LINK);
  assign can_emit = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_node_nxt  = cur_node_r;
    skipping_nxt  = skipping_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && in_data.kind == KIND_CHAR) begin
          if (skipping_r) begin
            if (in_data.last) begin
              skipping_nxt = 1'b0;
              cur_node_nxt = ROOT_NODE;
            end
          end else begin
            last_nxt  = in_data.last;
            hit_nxt   = rd_ok;
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        if (!need_out || can_emit) begin
          state_nxt = ST_IDLE;
          if (need_out) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{accepted: entry[ENTRY_W-1], stopped_early: ~last_r};
            cur_node_nxt  = ROOT_NODE;
            skipping_nxt  = ~last_r;
          end else begin
            cur_node_nxt = link;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cur_node_r  <= ROOT_NODE;
      skipping_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_node_r  <= cur_node_nxt;
      skipping_r  <= skipping_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/tb_trie_table_string_matcher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trie_table_string_matcher
// Self-checking bench for the trie table string matcher. Table writes and text
// strings are queued per session (random small dictionaries over a small
// alphabet, then lookups of whole words, prefixes, altered and extended words
// and loose requests). A clocked driver offers them in bursts, a clocked
// monitor checks every result against a walk predictor updated on acceptance.
// ----------------------------------------------------------------------------
module tb_trie_table_string_matcher;
  import ttsm_pkg::*;

  localparam int NUM_ITEMS  = 1450;
  localparam int HOLD_AT    = 600;
  localparam int HOLD_LEN   = 400;
  localparam int CYC_LIMIT  = 400000;
  localparam int TAIL_WAIT  = 20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  ttsm_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ttsm_out_t out_data;

  // walk predictor state
  bit [ENTRY_W-1:0] trie_tbl [0:65535];
  bit [NODE_W-1:0]  walk_node = ROOT_NODE;
  bit               walk_skip = 1'b0;
  ttsm_out_t        match_q [$];

  // table image as the stimulus builds it
  bit [ENTRY_W-1:0] plan_tbl [0:65535];
  ttsm_in_t         req_q [$];
  int               n_queued  = 0;

  int  n_accepted = 0;
  int  n_errors   = 0;
  int  cyc        = 0;
  int  burst_left = 0;
  int  gap_left   = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  trie_table_string_matcher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic walk_predict(input ttsm_in_t req);
    bit [ENTRY_W-1:0] ent;
    ttsm_out_t        res;
    if (req.kind == KIND_WRITE) begin
      trie_tbl[{req.entry_node, req.symbol}] = {req.accept, req.next_node};
    end else if (walk_skip) begin
      if (req.last) begin
        walk_skip = 1'b0;
        walk_node = ROOT_NODE;
      end
    end else begin
      ent = trie_tbl[{walk_node, req.symbol}];
      res.accepted = ent[NODE_W];
      if (req.last) begin
        res.stopped_early = 1'b0;
        match_q.push_back(res);
        walk_node = ROOT_NODE;
      end else if (ent[NODE_W-1:0] == NO_LINK) begin
        res.stopped_early = 1'b1;
        match_q.push_back(res);
        walk_skip = 1'b1;
        walk_node = ROOT_NODE;
      end else begin
        walk_node = ent[NODE_W-1:0];
      end
    end
  endtask

  task automatic push_write(input bit [7:0] node, input bit [7:0] sym,
                            input bit [7:0] link, input bit acc);
    ttsm_in_t r;
    r.kind       = KIND_WRITE;
    r.entry_node = node;
    r.symbol     = sym;
    r.next_node  = link;
    r.accept     = acc;
    r.last       = 1'($urandom_range(0, 1));
    plan_tbl[{node, sym}] = {acc, link};
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_char(input bit [7:0] sym, input bit last);
    ttsm_in_t r;
    r.kind       = KIND_CHAR;
    r.entry_node = 8'($urandom_range(0, 255));
    r.symbol     = sym;
    r.next_node  = 8'($urandom_range(0, 255));
    r.accept     = 1'($urandom_range(0, 1));
    r.last       = last;
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic drain_all();
    while (req_q.size() != 0 || in_valid || match_q.size() != 0) @(posedge clk);
  endtask

  // request driver: bursts of random length, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        walk_predict(in_data);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= req_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern rotates through four modes by cycle count, one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((cyc / 128) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 99) < 75);
          2: out_ready <= ($urandom_range(0, 99) < 35);
          default: out_ready <= cyc[1];
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ttsm_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (match_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %b", out_data));
      end else begin
        exp_r = match_q.pop_front();
        if (out_data.accepted !== exp_r.accepted)
          report_mismatch($sformatf("accepted %b, expected %b",
                                    out_data.accepted, exp_r.accepted));
        if (out_data.stopped_early !== exp_r.stopped_early)
          report_mismatch($sformatf("stopped_early %b, expected %b",
                                    out_data.stopped_early, exp_r.stopped_early));
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYC_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    bit [7:0] alpha [4];
    bit [7:0] wsym [8][8];
    int       wlen [8];
    bit [7:0] qsym [10];
    int       qlen, nwords, nqry, sess, w, k, j, mode;
    bit [7:0] node, link;
    bit [ENTRY_W-1:0] ent;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, last character
    push_char(8'h41, 1'b1);
    push_write(ROOT_NODE, 8'h00, 8'hFF, 1'b1);
    push_write(8'hFF, 8'hFF, NO_LINK, 1'b1);
    push_write(8'h00, 8'h55, 8'hAA, 1'b1);
    // last character on a missing link
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);
    // early stop, then the rest of the string is skipped
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h12, 1'b0);
    push_char(8'h34, 1'b1);
    // one-character word
    push_char(8'h00, 1'b1);
    // table write in the middle of a walk
    push_char(8'h00, 1'b0);
    push_write(8'hFF, 8'h7E, 8'h02, 1'b0);
    push_char(8'h7E, 1'b0);
    push_char(8'h01, 1'b1);
    // stop on the first character, skip a one-character tail, restart
    push_char(8'h33, 1'b0);
    push_char(8'h00, 1'b1);
    push_char(8'h00, 1'b1);
    drain_all();

    sess = 0;
    while (n_queued < NUM_ITEMS) begin
      for (k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(0, 255));
      nwords = $urandom_range(2, 6);
      for (w = 0; w < nwords; w++) begin
        wlen[w] = $urandom_range(1, 6);
        for (k = 0; k < wlen[w]; k++) wsym[w][k] = alpha[$urandom_range(0, 3)];
        node = ROOT_NODE;
        for (k = 0; k < wlen[w]; k++) begin
          ent = plan_tbl[{node, wsym[w][k]}];
          if (k == wlen[w] - 1) begin
            push_write(node, wsym[w][k], ent[NODE_W-1:0], 1'b1);
          end else if (ent[NODE_W-1:0] == NO_LINK) begin
            link = 8'($urandom_range(1, 255));
            push_write(node, wsym[w][k], link, ent[NODE_W]);
            node = link;
          end else begin
            node = ent[NODE_W-1:0];
          end
        end
      end
      nqry = $urandom_range(8, 16);
      for (j = 0; j < nqry; j++) begin
        w    = $urandom_range(0, nwords - 1);
        mode = $urandom_range(0, 9);
        qlen = wlen[w];
        for (k = 0; k < qlen; k++) qsym[k] = wsym[w][k];
        case (mode)
          4: qlen = $urandom_range(1, wlen[w]);
          5: qsym[$urandom_range(0, qlen - 1)] = alpha[$urandom_range(0, 3)];
          6: begin
            k = qlen;
            qlen = qlen + $urandom_range(1, 3);
            for (; k < qlen; k++) qsym[k] = alpha[$urandom_range(0, 3)];
          end
          7: begin
            qlen = $urandom_range(1, 6);
            for (k = 0; k < qlen; k++) qsym[k] = alpha[$urandom_range(0, 3)];
          end
          default: ;
        endcase
        if (mode == 8) begin
          push_write(8'($urandom_range(0, 255)),
                     $urandom_range(0, 1) ? alpha[$urandom_range(0, 3)]
                                          : 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (mode == 9) begin
          push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          for (k = 0; k < qlen; k++) push_char(qsym[k], k == qlen - 1);
        end
      end
      sess++;
      if (sess % 8 == 5) drain_all();
    end

    drain_all();
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ttsm_pkg.sv
design/ttsm_ram.sv
design/trie_table_string_matcher.sv
sim/tb_trie_table_string_matcher.sv
